@@ hw/rtl/delta_prefix_code_encoder_core_defines.svh @@
// assertion macros used by the checker
`ifndef DELTA_PREFIX_CODE_ENCODER_CORE_DEFINES_SVH
`define DELTA_PREFIX_CODE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define DPCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpce assertion failed");

// next-cycle implication, held off during reset
`define DPCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpce assertion failed");

`endif

@@ hw/rtl/dpce_pkg.sv @@
`default_nettype none

package dpce_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ESCAPE_BITS = 15;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    // escape prefix, sign bit, magnitude
    localparam int CODE_BITS   = 4 + 1 + ESCAPE_BITS;
    localparam int LEN_BITS    = $clog2(CODE_BITS + 1);
    // up to seven leftover bits plus one full code
    localparam int BUF_BITS    = CODE_BITS + 7;
    localparam int CNT_BITS    = $clog2(BUF_BITS + 1);
    localparam int BYTE_BITS   = 8;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [LEN_BITS-1:0]  len;
        logic                 last;
    } code_entry_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 final_flag;
    } out_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/delta_prefix_code_encoder_core.sv @@
// channel   direction  handshake            payload
// input     in         push / full          sample, final_sample
// result    out        empty / pop          code_byte, final_byte
// config    in         cfg_valid/cfg_ready  cfg_data (dc_offset)
//
// one sample word per cycle enters while the code queue has room
// byte rate: the packer emits at most one byte per cycle; codes are 2 to 6 bits long,
// and an escape code is 20 bits
// reset (rst_n low, asynchronous) clears predecessor to dc mode, queues empty
// either side may stall; the code queue and output queue decouple them

`default_nettype none

module delta_prefix_code_encoder_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // sample input
    input  wire logic signed [dpce_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                    final_sample,
    input  wire logic                                    push,
    output logic                                         full,
    // coded byte output
    output logic [dpce_pkg::BYTE_BITS-1:0]               code_byte,
    output logic                                         final_byte,
    output logic                                         empty,
    input  wire logic                                    pop,
    // dc_offset register write
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic signed [dpce_pkg::SAMPLE_BITS-1:0] cfg_data
);

    logic                  q_wr;
    dpce_pkg::code_entry_t q_wr_data;
    logic                  q_rd;
    dpce_pkg::code_entry_t q_rd_data;
    logic                  q_empty;

    // register is always writable
    assign cfg_ready = 1'b1;

    // front: difference against predecessor and prefix-code classification
    dpce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .final_sample (final_sample),
        .push         (push),
        .q_full       (full),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .q_wr         (q_wr),
        .q_wr_data    (q_wr_data)
    );

    // two-entry queue of codes between front and packer
    dpce_code_q u_code_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back: msb-first bit packing, flush padding, output queue
    dpce_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd_data  (q_rd_data),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .code_byte  (code_byte),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dpce_front.sv @@
`default_nettype none

module dpce_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [dpce_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                 final_sample,
    input  wire logic                                 push,
    input  wire logic                                 q_full,
    input  wire logic                                 cfg_valid,
    input  wire logic [dpce_pkg::SAMPLE_BITS-1:0]     cfg_data,
    output logic                                      q_wr,
    output dpce_pkg::code_entry_t                     q_wr_data
);

    logic [dpce_pkg::SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [dpce_pkg::SAMPLE_BITS-1:0] dc_reg, dc_next;
    logic                             first_reg, first_next;

    logic [dpce_pkg::SAMPLE_BITS-1:0] pred;
    logic [dpce_pkg::DIFF_BITS-1:0]   diff;
    logic [dpce_pkg::DIFF_BITS-1:0]   mag;
    logic [dpce_pkg::ESCAPE_BITS-1:0] esc_mag;
    logic                             neg;
    logic                             pos;

    assign q_wr = push & ~q_full;

    always_comb
    begin
        pred    = first_reg ? dc_reg : prev_reg;
        diff    = {sample[dpce_pkg::SAMPLE_BITS-1], sample}
                  - {pred[dpce_pkg::SAMPLE_BITS-1], pred};
        neg     = diff[dpce_pkg::DIFF_BITS-1];
        pos     = ~neg;
        mag     = neg ? (~diff + dpce_pkg::DIFF_BITS'(1)) : diff;
        // saturate the escape magnitude
        esc_mag = ((mag >> dpce_pkg::ESCAPE_BITS) != '0) ? '1
                  : dpce_pkg::ESCAPE_BITS'(mag);

        q_wr_data.last = final_sample;
        if (mag == '0)
        begin
            q_wr_data.code = '0;
            q_wr_data.len  = dpce_pkg::LEN_BITS'(2);
        end
        else if (mag == dpce_pkg::DIFF_BITS'(1))
        begin
            q_wr_data.code = dpce_pkg::CODE_BITS'({2'b01, pos});
            q_wr_data.len  = dpce_pkg::LEN_BITS'(3);
        end
        else if (mag <= dpce_pkg::DIFF_BITS'(3))
        begin
            q_wr_data.code = dpce_pkg::CODE_BITS'({2'b10, mag[0], pos});
            q_wr_data.len  = dpce_pkg::LEN_BITS'(4);
        end
        else if (mag <= dpce_pkg::DIFF_BITS'(5))
        begin
            q_wr_data.code = dpce_pkg::CODE_BITS'({3'b110, mag[0], pos});
            q_wr_data.len  = dpce_pkg::LEN_BITS'(5);
        end
        else if (mag <= dpce_pkg::DIFF_BITS'(7))
        begin
            q_wr_data.code = dpce_pkg::CODE_BITS'({4'b1110, mag[0], pos});
            q_wr_data.len  = dpce_pkg::LEN_BITS'(6);
        end
        else
        begin
            q_wr_data.code = {4'b1111, neg, esc_mag};
            q_wr_data.len  = dpce_pkg::LEN_BITS'(dpce_pkg::CODE_BITS);
        end
    end

    always_comb
    begin
        prev_next  = prev_reg;
        first_next = first_reg;
        dc_next    = cfg_valid ? cfg_data : dc_reg;
        if (q_wr)
        begin
            // end of block re-arms the dc predecessor
            prev_next  = final_sample ? '0 : sample;
            first_next = final_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            first_reg <= 1'b1;
            dc_reg    <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            first_reg <= first_next;
            dc_reg    <= dc_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dpce_code_q.sv @@
`default_nettype none

module dpce_code_q (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire dpce_pkg::code_entry_t wr_data,
    output logic                       full,
    input  wire logic                  rd_en,
    output dpce_pkg::code_entry_t      rd_data,
    output logic                       empty
);

    dpce_pkg::code_entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dpce_packer.sv @@
`default_nettype none

module dpce_packer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dpce_pkg::code_entry_t          q_rd_data,
    input  wire logic                           q_empty,
    output logic                                q_rd,
    output logic [dpce_pkg::BYTE_BITS-1:0]      code_byte,
    output logic                                final_byte,
    output logic                                empty,
    input  wire logic                           pop
);

    logic [dpce_pkg::BUF_BITS-1:0] buf_reg, buf_next;
    logic [dpce_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                          last_reg, last_next;

    logic [dpce_pkg::BUF_BITS-1:0] mbuf;
    logic [dpce_pkg::CNT_BITS-1:0] mcnt;
    logic                          mlast;
    logic                          emit_full, emit_pad;

    // output queue
    dpce_pkg::out_word_t out_mem [2];
    logic                out_wr_ptr_reg, out_wr_ptr_next;
    logic                out_rd_ptr_reg, out_rd_ptr_next;
    logic [1:0]          out_cnt_reg, out_cnt_next;
    logic                space, out_wr, out_rd;
    dpce_pkg::out_word_t out_word;

    assign space      = (out_cnt_reg != 2'd2);
    assign empty      = (out_cnt_reg == 2'd0);
    assign out_rd     = pop & ~empty;
    assign code_byte  = out_mem[out_rd_ptr_reg].data;
    assign final_byte = out_mem[out_rd_ptr_reg].final_flag;

    // merge a new code only while fewer than eight bits are held
    assign q_rd = (cnt_reg < dpce_pkg::CNT_BITS'(8)) & ~last_reg & ~q_empty;

    always_comb
    begin
        mbuf  = buf_reg;
        mcnt  = cnt_reg;
        mlast = last_reg;
        if (q_rd)
        begin
            mbuf  = (buf_reg << q_rd_data.len) | dpce_pkg::BUF_BITS'(q_rd_data.code);
            mcnt  = cnt_reg + dpce_pkg::CNT_BITS'(q_rd_data.len);
            mlast = q_rd_data.last;
        end

        emit_full = space & (mcnt >= dpce_pkg::CNT_BITS'(8));
        emit_pad  = space & mlast & (mcnt != '0) & (mcnt < dpce_pkg::CNT_BITS'(8));

        buf_next  = mbuf;
        cnt_next  = mcnt;
        last_next = mlast;
        out_word  = '0;
        out_wr    = emit_full | emit_pad;
        if (emit_full)
        begin
            out_word.data       = dpce_pkg::BYTE_BITS'(mbuf >> (mcnt - dpce_pkg::CNT_BITS'(8)));
            out_word.final_flag = mlast & (mcnt == dpce_pkg::CNT_BITS'(8));
            cnt_next            = mcnt - dpce_pkg::CNT_BITS'(8);
            last_next           = mlast & (mcnt != dpce_pkg::CNT_BITS'(8));
        end
        else if (emit_pad)
        begin
            // zero-pad the partial byte at end of block
            out_word.data       = dpce_pkg::BYTE_BITS'(mbuf << (dpce_pkg::CNT_BITS'(8) - mcnt));
            out_word.final_flag = 1'b1;
            cnt_next            = '0;
            last_next           = 1'b0;
        end

        out_wr_ptr_next = out_wr ? ~out_wr_ptr_reg : out_wr_ptr_reg;
        out_rd_ptr_next = out_rd ? ~out_rd_ptr_reg : out_rd_ptr_reg;
        out_cnt_next    = out_cnt_reg + {1'b0, out_wr} - {1'b0, out_rd};
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (out_wr)
        begin
            out_mem[out_wr_ptr_reg] <= out_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            out_wr_ptr_reg <= out_wr_ptr_next;
            out_rd_ptr_reg <= out_rd_ptr_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dpce_checker.sv @@
`default_nettype none

`include "delta_prefix_code_encoder_core_defines.svh"

module dpce_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           push,
    input wire logic                           full,
    input wire logic [dpce_pkg::BYTE_BITS-1:0] code_byte,
    input wire logic                           final_byte,
    input wire logic                           empty,
    input wire logic                           pop,
    input wire logic                           cfg_ready
);

    // config channel never back-pressures
    `DPCE_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
    // the input queue only fills after an accepted word
    `DPCE_ASSERT_NOW(a_full_rise, clk, rst_n, $rose(full), $past(push && !full))
    // a waiting result word holds until taken
    `DPCE_ASSERT_NEXT(a_out_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(code_byte) && $stable(final_byte))

endmodule

bind delta_prefix_code_encoder_core dpce_checker u_dpce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .code_byte    (code_byte),
    .final_byte   (final_byte),
    .empty        (empty),
    .pop          (pop),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

@@ dv/delta_prefix_code_encoder_core_tb.sv @@
`timescale 1ns / 1ps

module delta_prefix_code_encoder_core_tb;

    // prefix code bases, sign bit is added as the lsb
    localparam int ZERO_CODE      = 0;
    localparam int ONE_CODE_BASE  = 2;
    localparam int TWO_CODE_BASE  = 8;
    localparam int FOUR_CODE_BASE = 24;
    localparam int SIX_CODE_BASE  = 56;
    localparam int ESC_PREFIX     = 15;
    localparam int ESC_MAG_MAX    = (1 << dpce_pkg::ESCAPE_BITS) - 1;

    // run control
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TAIL_CYCLES    = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 140;
    localparam int PRESSURE_ITEMS = 40;

    logic                                    clk;
    logic                                    rst_n;
    logic signed [dpce_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    final_sample;
    logic                                    push;
    logic                                    full;
    logic [dpce_pkg::BYTE_BITS-1:0]          code_byte;
    logic                                    final_byte;
    logic                                    empty;
    logic                                    pop;
    logic                                    cfg_valid;
    logic                                    cfg_ready;
    logic signed [dpce_pkg::SAMPLE_BITS-1:0] cfg_data;

    // expected coded words, oldest first
    dpce_pkg::out_word_t expected_words[$];

    // predictor state
    logic signed [dpce_pkg::SAMPLE_BITS-1:0] dc_reg;
    logic signed [dpce_pkg::SAMPLE_BITS-1:0] prev_sample;
    logic                                    first_pending;
    logic [31:0]                             bit_acc;
    int unsigned                             bits_held;

    // shared run state
    int mismatch_count;
    int stall_cycles;
    int rx_wait;
    bit steady_flow;
    bit hold_req;

    delta_prefix_code_encoder_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .final_sample (final_sample),
        .push         (push),
        .full         (full),
        .code_byte    (code_byte),
        .final_byte   (final_byte),
        .empty        (empty),
        .pop          (pop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // back to the start of a block: dc mode, empty bit buffer
    function automatic void clear_block_state();
        prev_sample   = '0;
        first_pending = 1'b1;
        bit_acc       = '0;
        bits_held     = 0;
    endfunction

    // append n code bits msb first, queue every byte that fills
    function automatic void pack_bits(input int code, input int unsigned n);
        dpce_pkg::out_word_t w;
        bit_acc   = (bit_acc << n) | (32'(code) & ((32'd1 << n) - 32'd1));
        bits_held = bits_held + n;
        while (bits_held >= 8)
        begin
            bits_held    = bits_held - 8;
            w.data       = 8'(bit_acc >> bits_held);
            w.final_flag = 1'b0;
            expected_words.push_back(w);
        end
        bit_acc = bit_acc & ((32'd1 << bits_held) - 32'd1);
    endfunction

    // code one accepted sample and queue the words it completes
    function automatic void encode_sample(
        input logic signed [dpce_pkg::SAMPLE_BITS-1:0] value,
        input logic                                    last
    );
        int                  diff;
        int                  mag;
        int                  pos;
        dpce_pkg::out_word_t w;
        diff = int'(value) - (first_pending ? int'(dc_reg) : int'(prev_sample));
        mag  = (diff < 0) ? -diff : diff;
        pos  = (diff < 0) ? 0 : 1;
        if (mag == 0)
            pack_bits(ZERO_CODE, 2);
        else if (mag == 1)
            pack_bits(ONE_CODE_BASE + pos, 3);
        else if (mag <= 3)
            pack_bits(TWO_CODE_BASE + (mag - 2) * 2 + pos, 4);
        else if (mag <= 5)
            pack_bits(FOUR_CODE_BASE + (mag - 4) * 2 + pos, 5);
        else if (mag <= 7)
            pack_bits(SIX_CODE_BASE + (mag - 6) * 2 + pos, 6);
        else
        begin
            // escape: prefix, sign, saturated magnitude
            if (mag > ESC_MAG_MAX)
                mag = ESC_MAG_MAX;
            pack_bits(ESC_PREFIX, 4);
            pack_bits(1 - pos, 1);
            pack_bits(mag, dpce_pkg::ESCAPE_BITS);
        end
        prev_sample   = value;
        first_pending = 1'b0;
        if (last)
        begin
            if (bits_held > 0)
            begin
                // zero-padded tail byte
                w.data       = 8'(bit_acc << (8 - bits_held));
                w.final_flag = 1'b1;
                expected_words.push_back(w);
            end
            else
            begin
                // code ended on a byte boundary, mark the byte just made
                w            = expected_words.pop_back();
                w.final_flag = 1'b1;
                expected_words.push_back(w);
            end
            clear_block_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // every popped word is compared against the oldest expectation
    always @(posedge clk)
    begin : check_words
        dpce_pkg::out_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("word with nothing expected", code_byte, 0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (code_byte !== want.data)
                    report_mismatch("code_byte", code_byte, want.data);
                if (final_byte !== want.final_flag)
                    report_mismatch("final_byte", final_byte, want.final_flag);
            end
        end
    end

    // ends the run when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles at %0t", stall_cycles, $time);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly no gap, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random pop stalls, plus the long hold-off on request
    initial
    begin
        pop     = 1'b0;
        rx_wait = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rx_wait  = HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                pop <= 1'b0;
                rx_wait--;
            end
            else
            begin
                pop <= 1'b1;
                rx_wait = steady_flow ? 0 : gap_len();
            end
        end
    end

    // offer one sample word; returns at the edge that takes it, push still high
    task automatic send_sample(
        input logic signed [dpce_pkg::SAMPLE_BITS-1:0] value,
        input logic                                    last
    );
        int gap;
        gap = steady_flow ? 0 : gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        sample       <= value;
        final_sample <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        encode_sample(value, last);
    endtask

    // stop offering, then write dc_offset once every word is out and the block settled
    task automatic write_dc(input logic signed [dpce_pkg::SAMPLE_BITS-1:0] value);
        @(negedge clk);
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // a sample may still sit inside without having produced a byte
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        dc_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic sender_idle();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // next sample: mostly small steps, sometimes escapes and extremes
    function automatic logic signed [dpce_pkg::SAMPLE_BITS-1:0] next_sample(
        input logic signed [dpce_pkg::SAMPLE_BITS-1:0] last_value
    );
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 16'(int'(last_value) + int'($urandom_range(0, 18)) - 9);
        if (r < 80)
            return 16'(int'(last_value) + int'($urandom_range(0, 600)) - 300);
        if (r < 92)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    function automatic logic signed [dpce_pkg::SAMPLE_BITS-1:0] pick_dc();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every code class with both signs, saturation, exact-byte flush, one-sample block
    task automatic test_code_table();
        send_sample(16'sd0, 1'b0);      // zero difference from reset dc
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd4, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd6, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd8, 1'b0);      // smallest escape
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh8000, 1'b0);   // magnitude 32768 saturates
        send_sample(16'sh7fff, 1'b0);   // widest positive difference
        send_sample(16'sh8000, 1'b1);   // widest negative difference, flush
        // four 2-bit codes end exactly on a byte boundary
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        // block of a single sample
        send_sample(16'sd5, 1'b1);
        sender_idle();
    endtask

    // dc_offset at both extremes, a random value and back to zero
    task automatic test_dc_offset();
        write_dc(16'sh8000);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sd32760, 1'b1);
        write_dc(16'sh7fff);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8003, 1'b1);
        write_dc(pick_dc());
        send_sample(16'(int'(dc_reg) + 1), 1'b0);
        send_sample(16'(int'(dc_reg) - 6), 1'b0);
        // written mid-block: must not touch the running block
        write_dc(16'($urandom));
        send_sample(16'(int'(prev_sample) + 5), 1'b1);
        send_sample(dc_reg, 1'b1);
        write_dc(16'sh0000);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shfffe, 1'b1);
        sender_idle();
    endtask

    // random blocks, dc changes between some of them; first third without idling
    task automatic test_random_blocks();
        int                                    sent;
        int                                    blk_len;
        logic signed [dpce_pkg::SAMPLE_BITS-1:0] last_value;
        logic signed [dpce_pkg::SAMPLE_BITS-1:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady_flow = (sent < RANDOM_ITEMS / 3);
            if ($urandom_range(0, 3) == 0)
                write_dc(pick_dc());
            blk_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30)
                                                    : $urandom_range(1, 12);
            last_value = dc_reg;
            for (int i = 0; i < blk_len; i++)
            begin
                value = next_sample(last_value);
                send_sample(value, i == blk_len - 1);
                last_value = value;
            end
            sent += blk_len;
        end
        sender_idle();
        steady_flow = 1'b0;
    endtask

    // receiver holds off while escapes pour in, so the input side must stall
    task automatic test_output_backpressure();
        logic signed [dpce_pkg::SAMPLE_BITS-1:0] value;
        steady_flow = 1'b1;
        hold_req    = 1'b1;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
        begin
            value = (i % 2 == 0) ? 16'sh7fff - 16'($urandom_range(0, 100))
                                 : 16'sh8000 + 16'($urandom_range(0, 100));
            send_sample(value, i == PRESSURE_ITEMS - 1);
        end
        sender_idle();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        sample         = '0;
        final_sample   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        steady_flow    = 1'b0;
        hold_req       = 1'b0;
        dc_reg         = '0;
        clear_block_state();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_code_table();
        test_dc_offset();
        test_random_blocks();
        test_output_backpressure();

        // drain; a stuck block is caught by the watchdog
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
